>>> sv/psaw_pkg.sv
package psaw_pkg;

    // fixed formats
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 20;
    localparam int ACC_W       = 48;
    localparam int GAIN_W      = 32;
    localparam int ERR_W       = SAMPLE_BITS + 1;
    localparam int XLO_W       = 24;
    localparam int MB_W        = XLO_W + 1;
    localparam int PROD_W      = GAIN_W + MB_W;
    localparam int MACC_W      = GAIN_W + ACC_W;
    localparam int U_W         = ACC_W + 4;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // register indexes
    localparam logic [2:0] REG_PROP  = 3'd0;
    localparam logic [2:0] REG_INT   = 3'd1;
    localparam logic [2:0] REG_DER   = 3'd2;
    localparam logic [2:0] REG_POLE  = 3'd3;
    localparam logic [2:0] REG_BACK  = 3'd4;
    localparam logic [2:0] REG_LLOW  = 3'd5;
    localparam logic [2:0] REG_LHIGH = 3'd6;
    localparam logic [2:0] REG_MODE  = 3'd7;

    // anti-windup modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_ICLAMP = 2'd1;
    localparam logic [1:0] MODE_COND   = 2'd2;
    localparam logic [1:0] MODE_BACK   = 2'd3;

    // datapath micro-ops
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_PE     = 4'd2;
    localparam logic [3:0] OP_IE     = 4'd3;
    localparam logic [3:0] OP_DE     = 4'd4;
    localparam logic [3:0] OP_HALF1  = 4'd5;
    localparam logic [3:0] OP_SUM    = 4'd6;
    localparam logic [3:0] OP_HALF2  = 4'd7;
    localparam logic [3:0] OP_BC     = 4'd8;
    localparam logic [3:0] OP_ACC_LO = 4'd9;
    localparam logic [3:0] OP_ACC_HI = 4'd10;
    localparam logic [3:0] OP_INC    = 4'd11;
    localparam logic [3:0] OP_INT3   = 4'd12;
    localparam logic [3:0] OP_SUM3   = 4'd13;
    localparam logic [3:0] OP_OUT    = 4'd14;
    localparam logic [3:0] OP_DER    = 4'd15;

    // multiplier operand selects
    localparam logic [2:0] MA_PROP = 3'd0;
    localparam logic [2:0] MA_INT  = 3'd1;
    localparam logic [2:0] MA_DER  = 3'd2;
    localparam logic [2:0] MA_BACK = 3'd3;
    localparam logic [2:0] MA_POLE = 3'd4;

    localparam logic [1:0] MB_ERR = 2'd0;
    localparam logic [1:0] MB_XLO = 2'd1;
    localparam logic [1:0] MB_XHI = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] target;
        logic signed [SAMPLE_BITS-1:0] measured;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] drive;
        logic                          at_limit;
    } t_out;

    typedef struct packed {
        logic signed [GAIN_W-1:0]      prop_gain;
        logic signed [GAIN_W-1:0]      int_half_gain;
        logic signed [GAIN_W-1:0]      deriv_gain;
        logic signed [GAIN_W-1:0]      deriv_pole;
        logic signed [GAIN_W-1:0]      backcalc_half_gain;
        logic signed [SAMPLE_BITS-1:0] limit_low;
        logic signed [SAMPLE_BITS-1:0] limit_high;
        logic [1:0]                    windup_mode;
    } t_cfg;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] ma;
        logic [1:0] mb;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> sv/psaw_regs.sv
module psaw_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psaw_pkg::ADDR_W-1:0]   paddr,
    input  logic [psaw_pkg::DATA_W-1:0]   pwdata,
    output logic [psaw_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output psaw_pkg::t_cfg                o_cfg
);
    import psaw_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain          <= '0;
            r_cfg.int_half_gain      <= '0;
            r_cfg.deriv_gain         <= '0;
            r_cfg.deriv_pole         <= '0;
            r_cfg.backcalc_half_gain <= '0;
            r_cfg.limit_low          <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            r_cfg.limit_high         <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_cfg.windup_mode        <= MODE_NONE;
        end else if (wr_en) begin
            case (idx)
                REG_PROP:  r_cfg.prop_gain          <= pwdata;
                REG_INT:   r_cfg.int_half_gain      <= pwdata;
                REG_DER:   r_cfg.deriv_gain         <= pwdata;
                REG_POLE:  r_cfg.deriv_pole         <= pwdata;
                REG_BACK:  r_cfg.backcalc_half_gain <= pwdata;
                REG_LLOW:  r_cfg.limit_low          <= pwdata[SAMPLE_BITS-1:0];
                REG_LHIGH: r_cfg.limit_high         <= pwdata[SAMPLE_BITS-1:0];
                REG_MODE:  r_cfg.windup_mode        <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_PROP:  prdata = r_cfg.prop_gain;
            REG_INT:   prdata = r_cfg.int_half_gain;
            REG_DER:   prdata = r_cfg.deriv_gain;
            REG_POLE:  prdata = r_cfg.deriv_pole;
            REG_BACK:  prdata = r_cfg.backcalc_half_gain;
            REG_LLOW:  prdata = DATA_W'({r_cfg.limit_low});
            REG_LHIGH: prdata = DATA_W'({r_cfg.limit_high});
            REG_MODE:  prdata = DATA_W'(r_cfg.windup_mode);
            default:   prdata = '0;
        endcase
    end

endmodule

>>> sv/psaw_dp.sv
module psaw_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psaw_pkg::t_cfg i_cfg,
    input  psaw_pkg::t_cmd i_cmd,
    input  psaw_pkg::t_in  i_word,
    input  logic           i_stall,
    output logic           o_valid,
    output psaw_pkg::t_out o_word,
    output psaw_pkg::t_sts o_sts
);
    import psaw_pkg::*;

    localparam logic signed [63:0] ACC_MAX64 = (64'sd1 <<< (ACC_W-1)) - 64'sd1;
    localparam logic signed [63:0] ACC_MIN64 = -ACC_MAX64 - 64'sd1;
    localparam logic signed [63:0] SMP_MAX64 = (64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1;
    localparam logic signed [63:0] SMP_MIN64 = -SMP_MAX64 - 64'sd1;
    localparam logic signed [63:0] HALF64    = 64'sd1 <<< (FRAC_BITS-1);

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] x);
        if (x > ACC_MAX64) return ACC_MAX64[ACC_W-1:0];
        if (x < ACC_MIN64) return ACC_MIN64[ACC_W-1:0];
        return x[ACC_W-1:0];
    endfunction

    // low limit is tested first so inverted limits resolve the same way
    function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    logic signed [ERR_W-1:0]  r_e;
    logic signed [ACC_W-1:0]  r_pe, r_ie, r_de, r_int, r_der, r_x;
    logic signed [U_W-1:0]    r_u;
    logic signed [ACC_W:0]    r_inc;
    logic signed [MACC_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_flag1;
    logic                     r_ovalid;
    t_out                     r_out;

    logic signed [ERR_W-1:0]  n_e;
    logic signed [ACC_W-1:0]  n_pe, n_ie, n_de, n_int, n_der, n_x;
    logic signed [U_W-1:0]    n_u;
    logic signed [ACC_W:0]    n_inc;
    logic signed [MACC_W-1:0] n_acc;
    logic signed [PROD_W-1:0] n_prod;
    logic                     n_flag1;
    logic                     n_ovalid;
    t_out                     n_out;

    logic signed [GAIN_W-1:0] mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  lo_q, hi_q, ms;
    logic signed [63:0]       lo64, hi64, u64, int64, ie64, uc, rnd, icl;
    logic                     out_free;

    // limits in accumulator format
    assign lo_q = {{(ACC_W-SAMPLE_BITS-FRAC_BITS){i_cfg.limit_low[SAMPLE_BITS-1]}},
                   i_cfg.limit_low, {FRAC_BITS{1'b0}}};
    assign hi_q = {{(ACC_W-SAMPLE_BITS-FRAC_BITS){i_cfg.limit_high[SAMPLE_BITS-1]}},
                   i_cfg.limit_high, {FRAC_BITS{1'b0}}};
    assign lo64  = 64'(lo_q);
    assign hi64  = 64'(hi_q);
    assign u64   = 64'(r_u);
    assign int64 = 64'(r_int);
    assign ie64  = 64'(r_ie);
    assign ms    = sat48(64'(r_acc >>> FRAC_BITS));

    assign out_free       = !r_ovalid || !i_stall;
    assign o_sts.out_free = out_free;
    assign o_valid        = r_ovalid;
    assign o_word         = r_out;

    // shared multiplier operands
    always_comb begin
        case (i_cmd.ma)
            MA_PROP: mul_a = i_cfg.prop_gain;
            MA_INT:  mul_a = i_cfg.int_half_gain;
            MA_DER:  mul_a = i_cfg.deriv_gain;
            MA_BACK: mul_a = i_cfg.backcalc_half_gain;
            MA_POLE: mul_a = i_cfg.deriv_pole;
            default: mul_a = '0;
        endcase
        case (i_cmd.mb)
            MB_ERR:  mul_b = MB_W'(r_e);
            MB_XLO:  mul_b = {1'b0, r_x[XLO_W-1:0]};
            MB_XHI:  mul_b = {r_x[ACC_W-1], r_x[ACC_W-1:XLO_W]};
            default: mul_b = '0;
        endcase
        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // micro-op execution
    always_comb begin
        n_e = r_e; n_pe = r_pe; n_ie = r_ie; n_de = r_de;
        n_int = r_int; n_der = r_der; n_x = r_x; n_u = r_u;
        n_inc = r_inc; n_acc = r_acc; n_flag1 = r_flag1;
        n_out = r_out;
        n_ovalid = r_ovalid && i_stall;
        uc  = '0;
        rnd = '0;
        icl = '0;
        case (i_cmd.op)
            OP_LOAD: n_e = ERR_W'(i_word.target) - ERR_W'(i_word.measured);
            OP_PE:   n_pe = sat48(64'(r_prod));
            OP_IE:   n_ie = sat48(64'(r_prod));
            OP_DE:   n_de = sat48(64'(r_prod));
            OP_HALF1: begin
                n_der = sat48(64'(r_der) + 64'(r_de));
                case (i_cfg.windup_mode)
                    MODE_BACK:   n_int = r_int;
                    MODE_ICLAMP: begin
                        icl   = clamp64(64'(sat48(int64 + ie64)), lo64, hi64);
                        n_int = icl[ACC_W-1:0];
                    end
                    default:     n_int = sat48(int64 + ie64);
                endcase
            end
            OP_SUM: n_u = U_W'(r_pe) + U_W'(r_int) + U_W'(r_der);
            OP_HALF2: begin
                n_flag1 = 1'b0;
                case (i_cfg.windup_mode)
                    MODE_ICLAMP: begin
                        if (int64 == lo64 || int64 == hi64) n_flag1 = 1'b1;
                        else n_int = sat48(int64 + ie64);
                    end
                    MODE_COND: begin
                        if (((r_e > 0 && u64 > 0) || (r_e < 0 && u64 < 0)) &&
                            (u64 < lo64 || u64 > hi64)) begin
                            n_int = sat48(int64 - ie64);
                            n_u   = r_u - U_W'(r_ie);
                        end else begin
                            n_int = sat48(int64 + ie64);
                        end
                    end
                    default: n_int = sat48(int64 + ie64);
                endcase
            end
            OP_BC: begin
                if (u64 > hi64)      n_x = sat48(hi64 - u64);
                else if (u64 < lo64) n_x = sat48(lo64 - u64);
                else                 n_x = '0;
            end
            OP_ACC_LO: n_acc = MACC_W'(r_prod);
            OP_ACC_HI: n_acc = r_acc + (MACC_W'(r_prod) <<< XLO_W);
            OP_INC:    n_inc = (ACC_W+1)'(r_ie) + (ACC_W+1)'(ms);
            OP_INT3:   n_int = sat48(int64 + 64'(r_inc));
            OP_SUM3: begin
                n_u   = U_W'(r_pe) + U_W'(r_int) + U_W'(r_der);
                n_int = sat48(int64 + 64'(r_inc));
            end
            OP_OUT: begin
                uc = (i_cfg.windup_mode == MODE_ICLAMP) ? u64 : clamp64(u64, lo64, hi64);
                rnd = clamp64((uc + HALF64) >>> FRAC_BITS, SMP_MIN64, SMP_MAX64);
                n_out.drive    = rnd[SAMPLE_BITS-1:0];
                n_out.at_limit = (i_cfg.windup_mode == MODE_ICLAMP) ? r_flag1 :
                                 (uc == lo64 || uc == hi64);
                n_ovalid = 1'b1;
                n_x      = r_der;
            end
            OP_DER: n_der = sat48(64'(ms) - 64'(r_de));
            default: ;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int    <= '0;
            r_der    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_int    <= n_int;
            r_der    <= n_der;
            r_ovalid <= n_ovalid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_pe    <= n_pe;
        r_ie    <= n_ie;
        r_de    <= n_de;
        r_x     <= n_x;
        r_u     <= n_u;
        r_inc   <= n_inc;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_flag1 <= n_flag1;
        r_out   <= n_out;
    end

    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_OUT |=> o_valid)
        else $error("result not presented after output step");

    a_iclamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_HALF1 && i_cfg.windup_mode == MODE_ICLAMP && lo_q <= hi_q)
        |=> (r_int >= lo_q && r_int <= hi_q))
        else $error("clamped integral outside limits");

    a_drive_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT && i_cfg.windup_mode != MODE_ICLAMP &&
         i_cfg.limit_low <= i_cfg.limit_high)
        |=> (o_word.drive >= i_cfg.limit_low && o_word.drive <= i_cfg.limit_high))
        else $error("drive outside limits");

endmodule

>>> sv/psaw_ctrl.sv
module psaw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_mode,
    input  psaw_pkg::t_sts i_sts,
    output logic           o_stall,
    output psaw_pkg::t_cmd o_cmd
);
    import psaw_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MP    = 5'd1;
    localparam logic [4:0] S_MI    = 5'd2;
    localparam logic [4:0] S_MD    = 5'd3;
    localparam logic [4:0] S_DE    = 5'd4;
    localparam logic [4:0] S_HALF1 = 5'd5;
    localparam logic [4:0] S_SUM   = 5'd6;
    localparam logic [4:0] S_HALF2 = 5'd7;
    localparam logic [4:0] S_BLO   = 5'd8;
    localparam logic [4:0] S_BHI   = 5'd9;
    localparam logic [4:0] S_BADD  = 5'd10;
    localparam logic [4:0] S_BINC  = 5'd11;
    localparam logic [4:0] S_BINT  = 5'd12;
    localparam logic [4:0] S_BSUM  = 5'd13;
    localparam logic [4:0] S_OUT   = 5'd14;
    localparam logic [4:0] S_DLO   = 5'd15;
    localparam logic [4:0] S_DHI   = 5'd16;
    localparam logic [4:0] S_DADD  = 5'd17;
    localparam logic [4:0] S_DER   = 5'd18;

    logic [4:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    // sequencer
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_cmd.ma = MA_PROP;
        o_cmd.mb = MB_ERR;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.op = OP_LOAD;
                n_state  = S_MP;
            end
            S_MP: begin
                n_state = S_MI;
            end
            S_MI: begin
                o_cmd.op = OP_PE; o_cmd.ma = MA_INT; n_state = S_MD;
            end
            S_MD: begin
                o_cmd.op = OP_IE; o_cmd.ma = MA_DER; n_state = S_DE;
            end
            S_DE:    begin o_cmd.op = OP_DE;    n_state = S_HALF1; end
            S_HALF1: begin o_cmd.op = OP_HALF1; n_state = S_SUM;   end
            S_SUM:   begin o_cmd.op = OP_SUM;   n_state = S_HALF2; end
            S_HALF2: begin
                if (i_mode == MODE_BACK) begin
                    o_cmd.op = OP_BC; n_state = S_BLO;
                end else begin
                    o_cmd.op = OP_HALF2; n_state = S_OUT;
                end
            end
            S_BLO: begin
                o_cmd.ma = MA_BACK; o_cmd.mb = MB_XLO; n_state = S_BHI;
            end
            S_BHI: begin
                o_cmd.op = OP_ACC_LO; o_cmd.ma = MA_BACK; o_cmd.mb = MB_XHI;
                n_state = S_BADD;
            end
            S_BADD: begin o_cmd.op = OP_ACC_HI; n_state = S_BINC; end
            S_BINC: begin o_cmd.op = OP_INC;    n_state = S_BINT; end
            S_BINT: begin o_cmd.op = OP_INT3;   n_state = S_BSUM; end
            S_BSUM: begin o_cmd.op = OP_SUM3;   n_state = S_OUT;  end
            S_OUT: if (i_sts.out_free) begin
                o_cmd.op = OP_OUT;
                n_state  = S_DLO;
            end
            S_DLO: begin
                o_cmd.ma = MA_POLE; o_cmd.mb = MB_XLO; n_state = S_DHI;
            end
            S_DHI: begin
                o_cmd.op = OP_ACC_LO; o_cmd.ma = MA_POLE; o_cmd.mb = MB_XHI;
                n_state = S_DADD;
            end
            S_DADD: begin o_cmd.op = OP_ACC_HI; n_state = S_DER;  end
            S_DER:  begin o_cmd.op = OP_DER;    n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_state == S_MP)
        else $error("accepted word did not start the sequence");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_sts.out_free) |=> r_state == S_OUT)
        else $error("result step left while output busy");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DER |=> !o_stall)
        else $error("sequence did not return to idle");

endmodule

>>> sv/pid_step_anti_windup_unit.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_word  (target, measured)
// output    out        o_valid / i_stall   o_word  (drive, at_limit)
// config    in         psel/penable/pready paddr, pwdata, prdata
//
// One word at a time through a single shared 32x25 multiplier; the 48-bit
// coefficient products take two passes each.
// A new word is accepted only once the sequencer is back in idle. The result
// is registered, and the sequencer waits at the output step while a result is
// stalled. Synchronous active-low reset clears the integral and derivative
// state, the output valid and the configuration registers.
module pid_step_anti_windup_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  psaw_pkg::t_in                 i_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output psaw_pkg::t_out                o_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psaw_pkg::ADDR_W-1:0]   paddr,
    input  logic [psaw_pkg::DATA_W-1:0]   pwdata,
    output logic [psaw_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import psaw_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    psaw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psaw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (cfg.windup_mode),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    psaw_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_word  (i_word),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_word  (o_word),
        .o_sts   (sts)
    );

endmodule
